>>> rtl/core/rdsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsm_pkg: shared definitions for the dot-star pattern matcher
// Pattern size, special pattern bytes, register indexes and the control
// bundle that the top level broadcasts to every row cell.
// ----------------------------------------------------------------------------
package rdsm_pkg;

  // Largest pattern in bytes; the column holds one more bit (empty prefix)
  localparam int unsigned MAX_PATTERN = 32;
  localparam int unsigned COL_W       = MAX_PATTERN + 1;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned NUM_WORDS   = 4;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORD_A = 3'd0,
    CFG_WORD_B = 3'd1,
    CFG_WORD_C = 3'd2,
    CFG_WORD_D = 3'd3,
    CFG_LENGTH = 3'd4
  } cfg_idx_e;

  // Per-item control shared by all row cells
  typedef struct packed {
    logic       start;
    logic [7:0] text_byte;
  } cell_ctrl_t;

endpackage

>>> rtl/core/rdsm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsm_cell: one pattern row of the match column
// Computes the next match bit of its row from the old column bits of its own
// row and the row above, and from the new bit two rows above in the chain.
// ----------------------------------------------------------------------------
module rdsm_cell import rdsm_pkg::*; (
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] pat_byte_i,
  input  logic [7:0] prev_byte_i,
  input  logic       has_prev_i,
  input  logic       enable_i,
  input  logic       old_prev_i,
  input  logic       old_self_i,
  input  logic       chain_i,
  output logic       bit_o
);

  logic is_eq;
  logic is_dot;
  logic is_star;
  logic prev_ok;
  logic adv_bit;
  logic start_bit;

  // Classify the pattern byte against the text byte
  assign is_eq   = (pat_byte_i == ctrl_i.text_byte);
  assign is_dot  = (pat_byte_i == CHAR_DOT);
  assign is_star = (pat_byte_i == CHAR_STAR);
  assign prev_ok = (prev_byte_i == CHAR_DOT) || (prev_byte_i == ctrl_i.text_byte);

  // Advance: a literal equal byte wins over star handling
  always_comb begin
    if (is_eq || is_dot) begin
      adv_bit = old_prev_i;
    end else if (is_star && has_prev_i) begin
      adv_bit = chain_i | (prev_ok & old_self_i);
    end else begin
      adv_bit = 1'b0;
    end
  end

  // Empty text: a star may drop itself and the byte before it
  assign start_bit = is_star & has_prev_i & chain_i;

  // Rows beyond the pattern length stay cleared
  assign bit_o = enable_i & (ctrl_i.start ? start_bit : adv_bit);

endmodule

>>> rtl/core/regex_dot_star_matcher.sv
`timescale 1ns / 1ps
// Latency: a result item is valid in the cycle after its input item is taken.
// Throughput: one item per cycle unless a result waits on the consumer; the
// row chain is combinational and an output register decouples the results.
// Reset: clears the match column, the pattern words and the pattern length.
// ----------------------------------------------------------------------------
// regex_dot_star_matcher: streaming matcher for patterns with '.' and '*'
// Keeps one match bit per pattern prefix in a row of cells; each text byte
// advances the column, a start item loads the empty-text column.
// ----------------------------------------------------------------------------
module regex_dot_star_matcher import rdsm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [7:0]           text_byte_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 full_match_o
);

  logic [NUM_WORDS-1:0][WORD_W-1:0] pat_words_q;
  logic [LEN_W-1:0]                 pat_len_q;
  logic [MAX_PATTERN-1:0][7:0]      pat_bytes;
  logic [LEN_W-1:0]                 len_eff;

  logic [COL_W-1:0] col_q;
  logic [COL_W-1:0] col_d;
  logic             out_valid_q;
  logic             full_match_q;
  logic             match_d;
  logic             in_accept;
  cell_ctrl_t       ctrl;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_words_q <= '0;
      pat_len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WORD_A: pat_words_q[0] <= cfg_wdata_i;
        CFG_WORD_B: pat_words_q[1] <= cfg_wdata_i;
        CFG_WORD_C: pat_words_q[2] <= cfg_wdata_i;
        CFG_WORD_D: pat_words_q[3] <= cfg_wdata_i;
        CFG_LENGTH: pat_len_q      <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_bytes = pat_words_q;

  // Saturate the length at the pattern capacity
  assign len_eff = (pat_len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len_q;

  // Handshake: take an item whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign ctrl.start     = !command_i;
  assign ctrl.text_byte = text_byte_i;

  // Empty prefix matches only the empty text
  assign col_d[0] = ctrl.start;

  // Row cells, one per pattern byte
  for (genvar i = 1; i <= MAX_PATTERN; i++) begin : g_row
    logic [7:0] prev_byte;
    logic       has_prev;
    logic       chain;

    if (i >= 2) begin : g_mid
      assign prev_byte = pat_bytes[i-2];
      assign has_prev  = 1'b1;
      assign chain     = col_d[i-2];
    end else begin : g_first
      assign prev_byte = 8'h00;
      assign has_prev  = 1'b0;
      assign chain     = 1'b0;
    end

    rdsm_cell u_cell (
      .ctrl_i      (ctrl),
      .pat_byte_i  (pat_bytes[i-1]),
      .prev_byte_i (prev_byte),
      .has_prev_i  (has_prev),
      .enable_i    (len_eff >= LEN_W'(i)),
      .old_prev_i  (col_q[i-1]),
      .old_self_i  (col_q[i]),
      .chain_i     (chain),
      .bit_o       (col_d[i])
    );
  end

  // Pick the bit of the whole pattern
  assign match_d = col_d[len_eff];

  // Advance the column on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (in_accept) begin
      col_q <= col_d;
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      full_match_q <= match_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign full_match_o = full_match_q;

  // Checks
  a_start_loads_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !command_i |=> col_q[0])
    else $error("start item did not set the empty-prefix bit");

  a_byte_clears_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && command_i |=> !col_q[0])
    else $error("text byte left the empty-prefix bit set");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted item gave no result");

  a_empty_pattern_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !command_i && (len_eff == '0) |=> full_match_o)
    else $error("empty pattern failed to match empty text");

endmodule

>>> tb/regex_dot_star_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regex_dot_star_matcher_tb: self-checking testbench for the dot-star matcher
// A behavioral match column tracks every accepted item and predicts the
// full_match bit; results are compared in order as they leave the block.
// Directed cases cover text before any start, leading and literal stars,
// extreme bytes, length saturation and a pattern change mid-text. Random
// traffic then runs under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module regex_dot_star_matcher_tb;
  import rdsm_pkg::*;

  localparam int unsigned CLK_HALF_NS = 5;
  localparam int unsigned TIMEOUT_NS  = 5_000_000;
  localparam logic        CMD_START   = 1'b0;
  localparam logic        CMD_APPEND  = 1'b1;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [WORD_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 command_i;
  logic [7:0]           text_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 full_match_o;

  // Predictor copy of the registers and the match column
  logic [WORD_W-1:0] pattern_copy [NUM_WORDS];
  logic [LEN_W-1:0]  length_copy;
  logic [COL_W-1:0]  match_column;
  logic [WORD_W-1:0] pattern_next [NUM_WORDS];

  logic expected_match_q [$];
  int   error_count;
  int   send_idle_pct;
  int   recv_stall_pct;

  regex_dot_star_matcher DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .text_byte_i  (text_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .full_match_o (full_match_o)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Match column predictor
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pattern_char(int k);
    return pattern_copy[k >> 3][(k & 7) * 8 +: 8];
  endfunction

  function automatic int active_length();
    int len;
    len = int'(length_copy);
    if (len > MAX_PATTERN) len = MAX_PATTERN;
    return len;
  endfunction

  function automatic logic [COL_W-1:0] empty_text_column();
    logic [COL_W-1:0] col;
    int len;
    col = '0;
    col[0] = 1'b1;
    len = active_length();
    for (int i = 2; i <= len; i++) begin
      if (pattern_char(i - 1) == CHAR_STAR) col[i] = col[i - 2];
    end
    return col;
  endfunction

  function automatic logic [COL_W-1:0] step_column(logic [COL_W-1:0] prev, logic [7:0] c);
    logic [COL_W-1:0] nxt;
    logic [7:0] pc;
    logic [7:0] pb;
    int len;
    nxt = '0;
    len = active_length();
    for (int i = 1; i <= len; i++) begin
      pc = pattern_char(i - 1);
      // an equal byte wins even when both are stars
      if (pc == c || pc == CHAR_DOT) begin
        nxt[i] = prev[i - 1];
      end else if (pc == CHAR_STAR && i >= 2) begin
        pb = pattern_char(i - 2);
        nxt[i] = nxt[i - 2] | ((pb == CHAR_DOT || pb == c) & prev[i]);
      end
    end
    return nxt;
  endfunction

  // --------------------------------------------------------------------------
  // Predict on each accepted input item, check each accepted result item
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : predict_and_check
    logic want;
    if (!rst_ni) begin
      match_column = '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (command_i == CMD_START) match_column = empty_text_column();
        else match_column = step_column(match_column, text_byte_i);
        expected_match_q.push_back(match_column[active_length()]);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_match_q.size() == 0) begin
          $error("full_match: no item expected, got %0b", full_match_o);
          error_count++;
        end else begin
          want = expected_match_q.pop_front();
          if (full_match_o !== want) begin
            $error("full_match: expected %0b, actual %0b", want, full_match_o);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver: stall at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shared driving tasks
  // --------------------------------------------------------------------------
  // Send one item, idling first at random; valid stays high after acceptance
  task automatic send_item(input logic cmd, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    text_byte_i <= b;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // Drop valid and hold until every expected result has come
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_match_q.size() != 0 || out_valid_o) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write one register; caller lowers the write enable afterwards
  task automatic write_reg(input cfg_idx_e idx, input logic [WORD_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_WORD_A: pattern_copy[0] = data;
      CFG_WORD_B: pattern_copy[1] = data;
      CFG_WORD_C: pattern_copy[2] = data;
      CFG_WORD_D: pattern_copy[3] = data;
      CFG_LENGTH: length_copy = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_pattern(input logic [WORD_W-1:0] len_word);
    write_reg(CFG_WORD_A, pattern_next[0]);
    write_reg(CFG_WORD_B, pattern_next[1]);
    write_reg(CFG_WORD_C, pattern_next[2]);
    write_reg(CFG_WORD_D, pattern_next[3]);
    write_reg(CFG_LENGTH, len_word);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void set_pattern_text(input string s);
    for (int w = 0; w < NUM_WORDS; w++) pattern_next[w] = '0;
    for (int i = 0; i < s.len(); i++) pattern_next[i / 8][(i % 8) * 8 +: 8] = s[i];
  endfunction

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  // Column is all zero after reset, so appends never match until a start
  task automatic test_text_before_start();
    send_item(CMD_APPEND, "a");
    send_item(CMD_APPEND, 8'hFF);
    send_item(CMD_START, 8'h00);
    quiesce();
  endtask

  // Star at byte 0 has no row two above; a text star matches a pattern star
  task automatic test_leading_and_literal_star();
    set_pattern_text("*a");
    load_pattern(64'd2);
    send_item(CMD_START, 8'hFF);
    send_item(CMD_APPEND, CHAR_STAR);
    send_item(CMD_APPEND, "a");
    quiesce();
  endtask

  task automatic test_dot_star_extreme_bytes();
    set_pattern_text(".*");
    load_pattern(64'd2);
    send_item(CMD_START, 8'h00);
    send_item(CMD_APPEND, 8'h00);
    send_item(CMD_APPEND, 8'hFF);
    send_item(CMD_APPEND, CHAR_STAR);
    quiesce();
  endtask

  // Full 32-byte pattern; lengths above the maximum saturate
  task automatic test_length_saturation();
    string s;
    s = "";
    for (int i = 0; i < 16; i++) s = {s, "a*"};
    set_pattern_text(s);
    load_pattern(64'd33);
    send_item(CMD_START, 8'h5A);
    send_item(CMD_APPEND, "a");
    send_item(CMD_APPEND, "b");
    quiesce();
    write_reg(CFG_LENGTH, {WORD_W{1'b1}});
    cfg_we_i <= 1'b0;
    send_item(CMD_START, 8'hA5);
    quiesce();
  endtask

  // New pattern applies to the column as it stands
  task automatic test_pattern_change_mid_text();
    set_pattern_text("ab");
    load_pattern(64'd2);
    send_item(CMD_START, 8'h00);
    send_item(CMD_APPEND, "a");
    quiesce();
    set_pattern_text("ac");
    write_reg(CFG_WORD_A, pattern_next[0]);
    cfg_we_i <= 1'b0;
    send_item(CMD_APPEND, "c");
    quiesce();
  endtask

  // --------------------------------------------------------------------------
  // Random traffic
  // --------------------------------------------------------------------------
  function automatic logic [7:0] random_pattern_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 8'("a" + $urandom_range(2));
    if (r < 60) return CHAR_DOT;
    if (r < 82) return CHAR_STAR;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] random_text_char();
    int r;
    r = $urandom_range(99);
    if (r < 80) return 8'("a" + $urandom_range(2));
    if (r < 87) return CHAR_STAR;
    if (r < 92) return CHAR_DOT;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    int sent;
    int len;
    int r;
    int n_bytes;
    logic [WORD_W-1:0] len_word;
    sent = 0;
    quiesce();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (sent < n_items) begin
      // Fresh pattern; bytes past the length are fully random
      r = $urandom_range(99);
      if (r < 70) len = $urandom_range(10);
      else if (r < 92) len = $urandom_range(32, 11);
      else len = $urandom_range(63, 33);
      for (int k = 0; k < 4 * 8; k++) begin
        pattern_next[k / 8][(k % 8) * 8 +: 8] =
          (k < len) ? random_pattern_char() : 8'($urandom_range(255));
      end
      len_word = WORD_W'(len);
      if ($urandom_range(7) == 0) begin
        len_word[WORD_W-1:LEN_W] = (WORD_W - LEN_W)'({$urandom, $urandom});
      end
      quiesce();
      load_pattern(len_word);
      repeat ($urandom_range(6, 3)) begin
        r = $urandom_range(99);
        if (r < 85) begin
          // well-formed text; a few skip the start and continue the column
          if (r < 78) send_item(CMD_START, 8'($urandom_range(255)));
          n_bytes = $urandom_range(14);
          for (int b = 0; b < n_bytes; b++) send_item(CMD_APPEND, random_text_char());
          sent += n_bytes + 1;
        end else begin
          // noise: arbitrary commands and bytes
          n_bytes = $urandom_range(8, 1);
          for (int b = 0; b < n_bytes; b++) begin
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
          end
          sent += n_bytes;
        end
        if ($urandom_range(7) == 0) quiesce();
      end
    end
    quiesce();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_WORD_A;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    command_i      = CMD_START;
    text_byte_i    = '0;
    out_ready_i    = 1'b0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      pattern_copy[w] = '0;
      pattern_next[w] = '0;
    end
    length_copy  = '0;
    match_column = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_text_before_start();
    test_leading_and_literal_star();
    test_dot_star_extreme_bytes();
    test_length_saturation();
    test_pattern_change_mid_text();
    test_random_traffic(0, 0, 385);
    test_random_traffic(76, 0, 385);
    test_random_traffic(0, 76, 385);
    test_random_traffic(34, 34, 385);

    quiesce();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
